FILE: design/rds_pkg.sv
// shared types and constants of the reaction-diffusion stencil block
`timescale 1ns / 1ps

package rds_pkg;

  localparam int VAL_W     = 18;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_REACTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT     = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [GAIN_W-1:0]       gain_t;

  localparam gain_t RST_REACTION  = 16'd66;
  localparam gain_t RST_DIFFUSION = 16'd26214;
  localparam val_t  RST_LEFT      = 18'sd65536;
  localparam val_t  RST_RIGHT     = 18'sd0;

  typedef struct packed {
    val_t cell_value;
    logic row_end;
  } in_beat_t;

  typedef struct packed {
    val_t new_value;
    logic row_done;
  } out_beat_t;

  // one cell update: neighbors, center and last-cell flag
  typedef struct packed {
    val_t lft;
    val_t u;
    val_t rgt;
    logic done;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: design/rds_stream_if.sv
// valid/ready stream channel carrying one payload per beat
`timescale 1ns / 1ps

interface rds_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/rds_front.sv
// front end: holds the stencil window and turns cells into update jobs
`timescale 1ns / 1ps

module rds_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rds_pkg::in_beat_t in_beat,
  input  rds_pkg::val_t    left_value,
  input  rds_pkg::val_t    right_value,
  input  rds_pkg::q_stat_t q_stat,
  output logic             push,
  output rds_pkg::job_t    push_job
);

  rds_pkg::val_t older_r, older_nxt;
  rds_pkg::val_t middle_r, middle_nxt;
  logic          phase_r, phase_nxt;
  logic          pend_r, pend_nxt;
  rds_pkg::job_t pend_job_r, pend_job_nxt;
  logic          take;

  assign in_ready = !pend_r && !q_stat.full;
  assign take     = in_valid && in_ready;

  always_comb begin
    older_nxt    = older_r;
    middle_nxt   = middle_r;
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    pend_job_nxt = pend_job_r;
    push         = 1'b0;
    push_job     = pend_job_r;
    if (pend_r && !q_stat.full) begin
      push     = 1'b1;
      pend_nxt = 1'b0;
    end else if (take) begin
      if (!phase_r) begin
        if (in_beat.row_end) begin
          // one-cell row
          push     = 1'b1;
          push_job = '{lft: left_value, u: in_beat.cell_value, rgt: right_value, done: 1'b1};
        end else begin
          older_nxt  = left_value;
          middle_nxt = in_beat.cell_value;
          phase_nxt  = 1'b1;
        end
      end else begin
        push       = 1'b1;
        push_job   = '{lft: older_r, u: middle_r, rgt: in_beat.cell_value, done: 1'b0};
        older_nxt  = middle_r;
        middle_nxt = in_beat.cell_value;
        if (in_beat.row_end) begin
          pend_nxt     = 1'b1;
          pend_job_nxt = '{lft: middle_r, u: in_beat.cell_value, rgt: right_value,
                           done: 1'b1};
          older_nxt    = '0;
          middle_nxt   = '0;
          phase_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      middle_r <= '0;
      phase_r  <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      older_r  <= older_nxt;
      middle_r <= middle_nxt;
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
  end

endmodule

FILE: design/rds_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

module rds_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rds_pkg::job_t    push_job,
  input  logic             pop,
  output rds_pkg::job_t    head_job,
  output rds_pkg::q_stat_t q_stat
);

  rds_pkg::job_t                  mem_r [rds_pkg::QDEPTH];
  logic [rds_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rds_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rds_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign q_stat.full  = (count_r == rds_pkg::QCNT_W'(rds_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: design/rds_back.sv
// back end: three-stage euler update pipeline with output register
`timescale 1ns / 1ps

module rds_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rds_pkg::q_stat_t   q_stat,
  input  rds_pkg::job_t      head_job,
  output logic               pop,
  input  rds_pkg::gain_t     reaction_gain,
  input  rds_pkg::gain_t     diffusion_gain,
  output logic               out_valid,
  input  logic               out_ready,
  output rds_pkg::out_beat_t out_beat
);

  localparam int VW   = rds_pkg::VAL_W;
  localparam int GW   = rds_pkg::GAIN_W;
  localparam int OMW  = ((FRAC_BITS > VW - 1) ? FRAC_BITS : VW - 1) + 2;
  localparam int PW   = VW + OMW;
  localparam int LW   = PW - FRAC_BITS;
  localparam int RPW  = LW + GW + 1;
  localparam int RW   = RPW - FRAC_BITS;
  localparam int LAPW = VW + 2;
  localparam int DPW  = LAPW + GW + 1;
  localparam int DW   = DPW - FRAC_BITS;
  localparam int MW0  = (RW > DW) ? RW : DW;
  localparam int MW   = (MW0 > VW) ? MW0 : VW;
  localparam int SW   = MW + 2;

  localparam logic signed [OMW-1:0] ONE =
    {{(OMW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic adv;

  // stage 1: u*(1-u) product and laplacian
  logic                   s1_valid_r;
  rds_pkg::val_t          s1_u_r;
  logic                   s1_done_r;
  logic signed [PW-1:0]   s1_prod_r;
  logic signed [LAPW-1:0] s1_lap_r;
  logic signed [OMW-1:0]  one_minus_u;
  logic signed [PW-1:0]   prod_nxt;
  logic signed [LAPW-1:0] lap_nxt;

  // stage 2: gain products
  logic                  s2_valid_r;
  rds_pkg::val_t         s2_u_r;
  logic                  s2_done_r;
  logic signed [RW-1:0]  s2_react_r;
  logic signed [DW-1:0]  s2_diff_r;
  logic signed [LW-1:0]  logistic;
  logic signed [RPW-1:0] react_prod;
  logic signed [DPW-1:0] diff_prod;

  // stage 3: sum and saturate into the output register
  logic                  out_valid_r;
  rds_pkg::out_beat_t    out_beat_r;
  logic signed [SW-1:0]  sum;
  rds_pkg::val_t         sat;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    one_minus_u = ONE - OMW'(head_job.u);
    prod_nxt    = PW'(head_job.u) * PW'(one_minus_u);
    lap_nxt     = LAPW'(head_job.lft) - (LAPW'(head_job.u) <<< 1) + LAPW'(head_job.rgt);
  end

  always_comb begin
    logistic   = LW'(s1_prod_r >>> FRAC_BITS);
    react_prod = RPW'($signed({1'b0, reaction_gain})) * RPW'(logistic);
    diff_prod  = DPW'($signed({1'b0, diffusion_gain})) * DPW'(s1_lap_r);
  end

  always_comb begin
    sum = SW'(s2_u_r) + SW'(s2_react_r) + SW'(s2_diff_r);
    if (sum[SW-1:VW-1] != {(SW - VW + 1){sum[SW-1]}}) begin
      sat = sum[SW-1] ? {1'b1, {(VW - 1){1'b0}}} : {1'b0, {(VW - 1){1'b1}}};
    end else begin
      sat = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !q_stat.empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u_r     <= head_job.u;
      s1_done_r  <= head_job.done;
      s1_prod_r  <= prod_nxt;
      s1_lap_r   <= lap_nxt;
      s2_u_r     <= s1_u_r;
      s2_done_r  <= s1_done_r;
      s2_react_r <= RW'(react_prod >>> FRAC_BITS);
      s2_diff_r  <= DW'(diff_prod >>> FRAC_BITS);
      out_beat_r <= '{new_value: sat, row_done: s2_done_r};
    end
  end

endmodule

FILE: design/reaction_diffusion_stencil_step.sv
// top level: fisher-kpp explicit euler row stencil with config registers
// path: a job enters the 4-entry queue when the front pushes it and its result is valid
//   after the output register (front -> queue -> two multiply stages -> output register)
// throughput: one cell per cycle while the queue is not full; after the row_end cell of a
//   multi-cell row, in_ready stays low until the second job is pushed (one push per cycle)
// reset: synchronous active-low rst_n clears window, queue, pipeline valids, config defaults
`timescale 1ns / 1ps

module reaction_diffusion_stencil_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rds_stream_if.sink                        in_chan,
  rds_stream_if.source                      out_chan,
  input  logic                              cfg_we,
  input  logic [rds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rds_pkg::CFG_W-1:0]         cfg_data
);

  // configuration registers
  rds_pkg::gain_t reaction_gain_r;
  rds_pkg::gain_t diffusion_gain_r;
  rds_pkg::val_t  left_value_r;
  rds_pkg::val_t  right_value_r;

  // front/back link
  rds_pkg::q_stat_t q_stat;
  rds_pkg::job_t    push_job;
  rds_pkg::job_t    head_job;
  logic             q_push;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reaction_gain_r  <= rds_pkg::RST_REACTION;
      diffusion_gain_r <= rds_pkg::RST_DIFFUSION;
      left_value_r     <= rds_pkg::RST_LEFT;
      right_value_r    <= rds_pkg::RST_RIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rds_pkg::CFG_REACTION:  reaction_gain_r  <= cfg_data[rds_pkg::GAIN_W-1:0];
        rds_pkg::CFG_DIFFUSION: diffusion_gain_r <= cfg_data[rds_pkg::GAIN_W-1:0];
        rds_pkg::CFG_LEFT:      left_value_r     <= cfg_data[rds_pkg::VAL_W-1:0];
        rds_pkg::CFG_RIGHT:     right_value_r    <= cfg_data[rds_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // front: window of older/middle cell, splits the row_end beat of a multi-cell row into two jobs
  rds_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_beat     (in_chan.data),
    .left_value  (left_value_r),
    .right_value (right_value_r),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_job    (push_job)
  );

  // decoupling queue
  rds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // back: arithmetic pipeline, stalls as a whole on output backpressure
  rds_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head_job       (head_job),
    .pop            (q_pop),
    .reaction_gain  (reaction_gain_r),
    .diffusion_gain (diffusion_gain_r),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_beat       (out_chan.data)
  );

  // front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // back never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // a full queue holds off new input beats
  assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> !in_chan.ready)
    else $error("input ready while queue full");

endmodule
